// ----- rtl/ffseq_pkg.sv -----
// Shared types and constants of the flipbook frame sequencer.
`default_nettype none

package ffseq_pkg;

    localparam int UV_FRAC_BITS   = 16;
    localparam int AXIS_TILES_MAX = 64;

    localparam int ACC_W     = 16;
    localparam int SUM_W     = ACC_W + 1;
    localparam int CNT_W     = 12;
    localparam int N_W       = CNT_W + 1;
    localparam int BLEND_W   = 8;
    localparam int UV_W      = 17;
    localparam int CFG_TW    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam int T_W     = $clog2(AXIS_TILES_MAX + 1);
    localparam int REC_IW  = (AXIS_TILES_MAX > 1) ? $clog2(AXIS_TILES_MAX) : 1;
    localparam int REC_S   = UV_FRAC_BITS + T_W + REC_IW;
    localparam int REC_W   = REC_S + 1;
    localparam int EDGE_SH = REC_S - UV_FRAC_BITS;
    localparam int MUL_AW  = N_W;
    localparam int PROD_W  = MUL_AW + REC_W;

    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;
    localparam int DIV_CW = 5;

    localparam logic [DIV_CW-1:0] ITER_STEPS = DIV_CW'(SUM_W);
    localparam logic [DIV_CW-1:0] ITER_MOD   = DIV_CW'(SUM_W + 1);
    localparam logic [DIV_CW-1:0] ITER_BLEND = DIV_CW'(BLEND_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_X      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_Y      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_H       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_V       = CFG_IDX_W'(4);

    localparam logic [ACC_W-1:0]  PERIOD_RESET = ACC_W'(128);
    localparam logic [CFG_TW-1:0] TILES_RESET  = CFG_TW'(1);

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [UV_W-1:0] left;
        logic [UV_W-1:0] right;
        logic [UV_W-1:0] top;
        logic [UV_W-1:0] bottom;
    } t_rect;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOTAL,
        S_STEPS,
        S_WRAP,
        S_MOD,
        S_BLEND_GO,
        S_BLEND,
        S_GY,
        S_GX,
        S_EL,
        S_ER,
        S_ET,
        S_EB,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/ffseq_div.sv -----
// Shared radix-2 restoring divider with a per-request iteration count.
`default_nettype none

module ffseq_div import ffseq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic [DIV_NW-1:0] o_quot,
    output logic [DIV_DW-1:0] o_rem,
    output logic              o_done
);

    localparam logic [DIV_CW-1:0] NW_C = DIV_CW'(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_dsr;

    logic [DIV_DW:0]   w_trial;
    logic              w_ge;
    logic [DIV_DW:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.iters;
            r_dsr <= i_req.divisor;
            r_rem <= DIV_DW'(i_req.dividend >> i_req.iters);
            r_quo <= i_req.dividend << (NW_C - i_req.iters);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CW'(1);
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/flipbook_frame_sequencer_top.sv -----
// Flipbook frame sequencer: tile advance, crossfade weight and atlas rectangles.
// Usage: each transaction on the input channel (i_valid, o_stall, i_elapsed) is one
// display tick. The elapsed time is added to the time accumulator; whole frame
// periods are taken out and the tile counter advances by that many tiles, wrapping
// at tiles_x*tiles_y. One result transaction follows on the output channel
// (o_valid, i_stall) with the tile index, the blend weight and the current and
// next tile rectangles in Q1.16.
// The work is done by the shared one-bit-per-cycle divider (period division, tile
// wrap and blend weight) and by the single shared multiplier that walks the twelve
// geometry steps. o_stall is high while a tick is being worked on.
// The result sits in an output register; a stalled result holds while the next
// tick is computed, and the sequencer waits at its last step until it is taken.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write it only while idle, which the block itself does not enforce. Reset restores
// the register defaults and clears the accumulator, the tile counter and any
// pending result.
`default_nettype none

module flipbook_frame_sequencer_top import ffseq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ACC_W-1:0]     i_elapsed,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CNT_W-1:0]     o_tile_index,
    output logic [BLEND_W-1:0]   o_blend,
    output logic [UV_W-1:0]      o_cur_left,
    output logic [UV_W-1:0]      o_cur_right,
    output logic [UV_W-1:0]      o_cur_top,
    output logic [UV_W-1:0]      o_cur_bottom,
    output logic [UV_W-1:0]      o_nxt_left,
    output logic [UV_W-1:0]      o_nxt_right,
    output logic [UV_W-1:0]      o_nxt_top,
    output logic [UV_W-1:0]      o_nxt_bottom
);

    t_state r_state, n_state;

    logic [ACC_W-1:0]  r_period;
    logic [CFG_TW-1:0] r_tiles_x;
    logic [CFG_TW-1:0] r_tiles_y;
    logic              r_flip_h;
    logic              r_flip_v;

    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_counter;

    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_steps;
    logic [N_W-1:0]     r_total;
    logic [BLEND_W-1:0] r_blend;
    logic               r_sel;
    logic [T_W-1:0]     r_x;
    logic [T_W-1:0]     r_y;
    t_rect              r_cur_rect;
    t_rect              r_nxt_rect;
    t_rect              n_rect;

    logic               r_out_valid;
    logic [CNT_W-1:0]   r_out_tile;
    logic [BLEND_W-1:0] r_out_blend;
    t_rect              r_out_cur;
    t_rect              r_out_nxt;

    logic [ACC_W-1:0]  w_period;
    logic [T_W-1:0]    w_tx;
    logic [T_W-1:0]    w_ty;
    logic [REC_W-1:0]  w_recip [AXIS_TILES_MAX];
    logic [REC_W-1:0]  w_rec_tx;
    logic [REC_W-1:0]  w_rec_ty;
    logic [N_W-1:0]    w_n;
    logic [MUL_AW-1:0] w_mul_a;
    logic [REC_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [UV_W-1:0]   w_edge;
    logic [N_W-1:0]    w_y_raw;
    logic [N_W-1:0]    w_x_raw;
    logic              w_wrap;
    logic [CNT_W-1:0]  w_cnt0;
    logic [SUM_W-1:0]  w_steps0;
    logic              w_out_free;

    t_div_req          w_div_req;
    logic [DIV_NW-1:0] w_div_quot;
    logic [DIV_DW-1:0] w_div_rem;
    logic              w_div_done;

    for (genvar g = 0; g < AXIS_TILES_MAX; g++) begin : g_recip
        localparam longint unsigned RV = ((longint'(1) << REC_S) + g) / (g + 1);
        assign w_recip[g] = REC_W'(RV);
    end

    always_comb begin
        if (r_tiles_x == '0) begin
            w_tx = T_W'(1);
        end else if (32'(r_tiles_x) > AXIS_TILES_MAX) begin
            w_tx = T_W'(AXIS_TILES_MAX);
        end else begin
            w_tx = T_W'(r_tiles_x);
        end
        if (r_tiles_y == '0) begin
            w_ty = T_W'(1);
        end else if (32'(r_tiles_y) > AXIS_TILES_MAX) begin
            w_ty = T_W'(AXIS_TILES_MAX);
        end else begin
            w_ty = T_W'(r_tiles_y);
        end
    end

    assign w_period = (r_period == '0) ? ACC_W'(1) : r_period;
    assign w_rec_tx = w_recip[REC_IW'(w_tx - T_W'(1))];
    assign w_rec_ty = w_recip[REC_IW'(w_ty - T_W'(1))];
    assign w_n      = r_sel ? ({1'b0, r_counter} + N_W'(1)) : {1'b0, r_counter};

    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_edge  = w_prod[EDGE_SH +: UV_W];
    assign w_y_raw = w_prod[REC_S +: N_W];
    assign w_x_raw = w_n - w_prod[N_W-1:0];

    assign w_wrap   = ({1'b0, r_counter} + N_W'(1)) >= r_total;
    assign w_cnt0   = w_wrap ? '0 : r_counter;
    assign w_steps0 = w_wrap ? (r_steps - SUM_W'(1)) : r_steps;

    assign w_out_free = !r_out_valid || !i_stall;

    ffseq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        n_rect    = r_sel ? r_nxt_rect : r_cur_rect;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_TOTAL;
                end
            end
            S_TOTAL: begin
                w_mul_a            = MUL_AW'(w_tx);
                w_mul_b            = REC_W'(w_ty);
                w_div_req.start    = 1'b1;
                w_div_req.iters    = ITER_STEPS;
                w_div_req.dividend = (r_sum == '0) ? '0 : DIV_NW'(r_sum - SUM_W'(1));
                w_div_req.divisor  = w_period;
                n_state            = S_STEPS;
            end
            S_STEPS: begin
                if (w_div_done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (r_steps == '0) begin
                    n_state = S_BLEND_GO;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.iters    = ITER_MOD;
                    w_div_req.dividend = DIV_NW'(w_cnt0) + DIV_NW'(w_steps0);
                    w_div_req.divisor  = DIV_DW'(r_total);
                    n_state            = S_MOD;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_state = S_BLEND_GO;
                end
            end
            S_BLEND_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.iters    = ITER_BLEND;
                w_div_req.dividend = {r_acc, BLEND_W'(0)} - DIV_NW'(r_acc);
                w_div_req.divisor  = w_period;
                n_state            = S_BLEND;
            end
            S_BLEND: begin
                if (w_div_done) begin
                    n_state = S_GY;
                end
            end
            S_GY: begin
                w_mul_a = w_n;
                w_mul_b = w_rec_tx;
                n_state = S_GX;
            end
            S_GX: begin
                w_mul_a = MUL_AW'(r_y);
                w_mul_b = REC_W'(w_tx);
                n_state = S_EL;
            end
            S_EL: begin
                w_mul_a = MUL_AW'(r_x);
                w_mul_b = w_rec_tx;
                if (r_flip_h) begin
                    n_rect.right = w_edge;
                end else begin
                    n_rect.left = w_edge;
                end
                n_state = S_ER;
            end
            S_ER: begin
                w_mul_a = MUL_AW'(r_x) + MUL_AW'(1);
                w_mul_b = w_rec_tx;
                if (r_flip_h) begin
                    n_rect.left = w_edge;
                end else begin
                    n_rect.right = w_edge;
                end
                n_state = S_ET;
            end
            S_ET: begin
                w_mul_a = MUL_AW'(r_y);
                w_mul_b = w_rec_ty;
                if (r_flip_v) begin
                    n_rect.bottom = w_edge;
                end else begin
                    n_rect.top = w_edge;
                end
                n_state = S_EB;
            end
            S_EB: begin
                w_mul_a = MUL_AW'(r_y) + MUL_AW'(1);
                w_mul_b = w_rec_ty;
                if (r_flip_v) begin
                    n_rect.top = w_edge;
                end else begin
                    n_rect.bottom = w_edge;
                end
                n_state = r_sel ? S_DONE : S_GY;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_tiles_x   <= TILES_RESET;
            r_tiles_y   <= TILES_RESET;
            r_flip_h    <= 1'b0;
            r_flip_v    <= 1'b0;
            r_acc       <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_PERIOD: r_period  <= i_cfg_data;
                    CFG_TILES_X:      r_tiles_x <= i_cfg_data[CFG_TW-1:0];
                    CFG_TILES_Y:      r_tiles_y <= i_cfg_data[CFG_TW-1:0];
                    CFG_FLIP_H:       r_flip_h  <= i_cfg_data[0];
                    CFG_FLIP_V:       r_flip_v  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_STEPS && w_div_done) begin
                r_acc <= (r_sum == '0) ? '0 : (w_div_rem + ACC_W'(1));
            end
            if (r_state == S_MOD && w_div_done) begin
                r_counter <= w_div_rem[CNT_W-1:0];
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_sum <= {1'b0, r_acc} + {1'b0, i_elapsed};
                end
            end
            S_TOTAL: begin
                r_total <= w_prod[N_W-1:0];
            end
            S_STEPS: begin
                if (w_div_done) begin
                    r_steps <= w_div_quot[SUM_W-1:0];
                end
            end
            S_BLEND: begin
                if (w_div_done) begin
                    r_blend <= w_div_quot[BLEND_W-1:0];
                    r_sel   <= 1'b0;
                end
            end
            S_GY: begin
                r_y <= (w_y_raw >= N_W'(w_ty)) ? '0 : T_W'(w_y_raw);
            end
            S_GX: begin
                r_x <= (w_x_raw >= N_W'(w_tx)) ? '0 : T_W'(w_x_raw);
            end
            S_EL, S_ER, S_ET, S_EB: begin
                if (r_sel) begin
                    r_nxt_rect <= n_rect;
                end else begin
                    r_cur_rect <= n_rect;
                end
                if (r_state == S_EB) begin
                    r_sel <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_tile  <= r_counter;
                    r_out_blend <= r_blend;
                    r_out_cur   <= r_cur_rect;
                    r_out_nxt   <= r_nxt_rect;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall      = r_state != S_IDLE;
    assign o_valid      = r_out_valid;
    assign o_tile_index = r_out_tile;
    assign o_blend      = r_out_blend;
    assign o_cur_left   = r_out_cur.left;
    assign o_cur_right  = r_out_cur.right;
    assign o_cur_top    = r_out_cur.top;
    assign o_cur_bottom = r_out_cur.bottom;
    assign o_nxt_left   = r_out_nxt.left;
    assign o_nxt_right  = r_out_nxt.right;
    assign o_nxt_top    = r_out_nxt.top;
    assign o_nxt_bottom = r_out_nxt.bottom;

endmodule

`default_nettype wire

// ----- test/flipbook_frame_checker.sv -----
// Checker for the flipbook frame sequencer: predicts each tick's result and compares it.
module flipbook_frame_checker import ffseq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_stall,
    input  logic [ACC_W-1:0]     i_elapsed,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [CNT_W-1:0]     i_tile_index,
    input  logic [BLEND_W-1:0]   i_blend,
    input  logic [UV_W-1:0]      i_cur_left,
    input  logic [UV_W-1:0]      i_cur_right,
    input  logic [UV_W-1:0]      i_cur_top,
    input  logic [UV_W-1:0]      i_cur_bottom,
    input  logic [UV_W-1:0]      i_nxt_left,
    input  logic [UV_W-1:0]      i_nxt_right,
    input  logic [UV_W-1:0]      i_nxt_top,
    input  logic [UV_W-1:0]      i_nxt_bottom,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CNT_W-1:0]   tile_index;
        logic [BLEND_W-1:0] blend;
        t_rect              cur;
        t_rect              nxt;
    } t_frame;

    logic [ACC_W-1:0]  period_reg;
    logic [CFG_TW-1:0] tiles_x_reg;
    logic [CFG_TW-1:0] tiles_y_reg;
    logic              flip_h_reg;
    logic              flip_v_reg;
    int unsigned       time_acc;
    int unsigned       tile_count;
    t_frame            frame_q[$];
    int                err_count = 0;

    function automatic int unsigned clamp_tiles(input logic [CFG_TW-1:0] t);
        if (t < 1) return 1;
        if (t > AXIS_TILES_MAX) return AXIS_TILES_MAX;
        return 32'(t);
    endfunction

    function automatic logic [UV_W-1:0] uv_edge(input int unsigned k, input int unsigned tiles);
        return UV_W'((k << UV_FRAC_BITS) / tiles);
    endfunction

    function automatic t_rect atlas_rect(input int unsigned n, input int unsigned tx,
                                         input int unsigned ty);
        int unsigned row;
        int unsigned col;
        t_rect       r;
        row = n / tx;
        if (row >= ty) row = 0;
        col = n - row * tx;
        if (col >= tx) col = 0;
        if (flip_h_reg) begin
            r.left  = uv_edge(col + 1, tx);
            r.right = uv_edge(col, tx);
        end else begin
            r.left  = uv_edge(col, tx);
            r.right = uv_edge(col + 1, tx);
        end
        if (flip_v_reg) begin
            r.top    = uv_edge(row + 1, ty);
            r.bottom = uv_edge(row, ty);
        end else begin
            r.top    = uv_edge(row, ty);
            r.bottom = uv_edge(row + 1, ty);
        end
        return r;
    endfunction

    // Advances the accumulator and tile counter by one tick and returns its result.
    function automatic t_frame advance_tick(input logic [ACC_W-1:0] elapsed);
        int unsigned per;
        int unsigned tx;
        int unsigned ty;
        int unsigned total;
        int unsigned sum;
        int unsigned steps;
        int unsigned wgt;
        t_frame      f;
        per   = (period_reg == 0) ? 1 : period_reg;
        tx    = clamp_tiles(tiles_x_reg);
        ty    = clamp_tiles(tiles_y_reg);
        total = tx * ty;
        sum   = time_acc + elapsed;
        steps = 0;
        if (sum > per) begin
            steps = (sum - 1) / per;
            sum   = sum - steps * per;
        end
        time_acc = sum & 16'hFFFF;
        if (steps > 0) begin
            if (tile_count + 1 >= total) begin
                tile_count = 0;
                steps      = steps - 1;
            end
            tile_count = (tile_count + steps) % total;
        end
        tile_count = tile_count & 12'hFFF;
        wgt = (255 * time_acc) / per;
        if (wgt > 255) wgt = 255;
        f.tile_index = CNT_W'(tile_count);
        f.blend      = BLEND_W'(wgt);
        f.cur        = atlas_rect(tile_count, tx, ty);
        f.nxt        = atlas_rect(tile_count + 1, tx, ty);
        return f;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame exp_f;
        if (!i_rst_n) begin
            period_reg  = PERIOD_RESET;
            tiles_x_reg = TILES_RESET;
            tiles_y_reg = TILES_RESET;
            flip_h_reg  = 1'b0;
            flip_v_reg  = 1'b0;
            time_acc    = 0;
            tile_count  = 0;
            frame_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_PERIOD: period_reg  = i_cfg_data;
                    CFG_TILES_X:      tiles_x_reg = i_cfg_data[CFG_TW-1:0];
                    CFG_TILES_Y:      tiles_y_reg = i_cfg_data[CFG_TW-1:0];
                    CFG_FLIP_H:       flip_h_reg  = i_cfg_data[0];
                    CFG_FLIP_V:       flip_v_reg  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_tick_valid && !i_tick_stall) frame_q.push_back(advance_tick(i_elapsed));
            if (i_res_valid && !i_res_stall) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: result transaction with no tick outstanding, tile %0d",
                             $time, i_tile_index);
                    err_count++;
                end else begin
                    exp_f = frame_q.pop_front();
                    check_field("tile_index", exp_f.tile_index, i_tile_index);
                    check_field("blend", exp_f.blend, i_blend);
                    check_field("cur_left", exp_f.cur.left, i_cur_left);
                    check_field("cur_right", exp_f.cur.right, i_cur_right);
                    check_field("cur_top", exp_f.cur.top, i_cur_top);
                    check_field("cur_bottom", exp_f.cur.bottom, i_cur_bottom);
                    check_field("nxt_left", exp_f.nxt.left, i_nxt_left);
                    check_field("nxt_right", exp_f.nxt.right, i_nxt_right);
                    check_field("nxt_top", exp_f.nxt.top, i_nxt_top);
                    check_field("nxt_bottom", exp_f.nxt.bottom, i_nxt_bottom);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= frame_q.size();
    end

endmodule

// ----- test/testbench.sv -----
// Top of the flipbook frame sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
    import ffseq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_FRAME_PERIOD;
    logic [CFG_DW-1:0]    i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic [ACC_W-1:0]     i_elapsed  = '0;
    logic                 i_stall    = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [CNT_W-1:0]     o_tile_index;
    logic [BLEND_W-1:0]   o_blend;
    logic [UV_W-1:0]      o_cur_left, o_cur_right, o_cur_top, o_cur_bottom;
    logic [UV_W-1:0]      o_nxt_left, o_nxt_right, o_nxt_top, o_nxt_bottom;
    int                   errors;
    int                   pending;

    // 0: sender idles a little, receiver a lot; 1: the reverse; 2: no idling.
    int idle_mode = 0;
    int phase_no  = -1;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #4 i_clk = ~i_clk;

    flipbook_frame_sequencer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_elapsed    (i_elapsed),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_index (o_tile_index),
        .o_blend      (o_blend),
        .o_cur_left   (o_cur_left),
        .o_cur_right  (o_cur_right),
        .o_cur_top    (o_cur_top),
        .o_cur_bottom (o_cur_bottom),
        .o_nxt_left   (o_nxt_left),
        .o_nxt_right  (o_nxt_right),
        .o_nxt_top    (o_nxt_top),
        .o_nxt_bottom (o_nxt_bottom)
    );

    flipbook_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (i_valid),
        .i_tick_stall (o_stall),
        .i_elapsed    (i_elapsed),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_tile_index (o_tile_index),
        .i_blend      (o_blend),
        .i_cur_left   (o_cur_left),
        .i_cur_right  (o_cur_right),
        .i_cur_top    (o_cur_top),
        .i_cur_bottom (o_cur_bottom),
        .i_nxt_left   (o_nxt_left),
        .i_nxt_right  (o_nxt_right),
        .i_nxt_top    (o_nxt_top),
        .i_nxt_bottom (o_nxt_bottom),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // The long hold-off lets the block fill up and push back on the tick channel.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && phase_no == 12) begin
            i_stall   <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= 600;
        end else begin
            i_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 80 :
                                             (idle_mode == 1) ? 23 : 0));
        end
    end

    task automatic send_tick(input logic [ACC_W-1:0] elapsed);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 80 : 0;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_elapsed <= elapsed;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CFG_DW-1:0] per, input logic [CFG_DW-1:0] tx,
                                 input logic [CFG_DW-1:0] ty, input logic [CFG_DW-1:0] fh,
                                 input logic [CFG_DW-1:0] fv);
        write_reg(CFG_FRAME_PERIOD, per);
        write_reg(CFG_TILES_X, tx);
        write_reg(CFG_TILES_Y, ty);
        write_reg(CFG_FLIP_H, fh);
        write_reg(CFG_FLIP_V, fv);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [ACC_W-1:0]  per;
        logic [CFG_TW-1:0] tx;
        logic [CFG_TW-1:0] ty;
        logic [8:0]        pad_x;
        logic [8:0]        pad_y;
        logic [14:0]       pad_h;
        logic [14:0]       pad_v;
        logic [ACC_W-1:0]  el;
        int unsigned       max_el;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a tick that fills the accumulator exactly, then overflow.
        send_tick(16'd0);
        send_tick(16'd128);
        send_tick(16'd1);
        send_tick(16'hFFFF);
        drain();
        apply_setting(16'hFFFF, 16'hFFC0, 16'h0040, 16'hFFFF, 16'h0001);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        drain();
        apply_setting(16'd1, 16'd64, 16'd64, 16'd0, 16'd0);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd4000);
        send_tick(16'd0);
        drain();
        // A zero period, and a small atlas that leaves the counter out of range.
        apply_setting(16'd0, 16'd3, 16'd5, 16'd0, 16'd1);
        send_tick(16'd0);
        send_tick(16'd2);
        send_tick(16'd1);
        send_tick(16'hFFFF);
        drain();
        // Tile counts outside 1..64 are clamped.
        apply_setting(16'd300, 16'd0, 16'd127, 16'd1, 16'd0);
        send_tick(16'd300);
        send_tick(16'd299);
        send_tick(16'hFFFF);
        send_tick(16'd7);
        drain();
        apply_setting(16'd2, 16'd100, 16'd0, 16'd1, 16'd1);
        send_tick(16'd1);
        send_tick(16'd1);
        send_tick(16'd1);
        drain();

        for (int ph = 0; ph < 15; ph++) begin
            idle_mode <= ph / 5;
            phase_no  <= ph;
            case ($urandom_range(4))
                0:       per = ACC_W'($urandom_range(1, 16));
                1:       per = ACC_W'($urandom_range(17, 1000));
                2:       per = ACC_W'($urandom_range(65535));
                3:       per = ($urandom_range(2) == 0) ? 16'd0 :
                               ($urandom_range(1) == 0) ? 16'd1 : 16'hFFFF;
                default: per = ACC_W'($urandom_range(1000, 8000));
            endcase
            tx = CFG_TW'(($urandom_range(7) == 0) ? $urandom_range(127) :
                                                    $urandom_range(1, 64));
            ty = CFG_TW'(($urandom_range(7) == 0) ? $urandom_range(127) :
                                                    $urandom_range(1, 64));
            if (ph == 4) begin
                tx = 7'd64;
                ty = 7'd64;
            end
            pad_x = 9'($urandom_range(511));
            pad_y = 9'($urandom_range(511));
            pad_h = 15'($urandom_range(32767));
            pad_v = 15'($urandom_range(32767));
            apply_setting(per, {pad_x, tx}, {pad_y, ty},
                          {pad_h, 1'($urandom_range(1))}, {pad_v, 1'($urandom_range(1))});
            max_el = (per == 0) ? 2 : 2 * per;
            if (max_el > 65535) max_el = 65535;
            for (int n = 0; n < 50; n++) begin
                case ($urandom_range(5))
                    0:       el = ACC_W'($urandom_range(65535));
                    1:       el = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
                    default: el = ACC_W'($urandom_range(max_el));
                endcase
                send_tick(el);
            end
            drain();
        end

        repeat (70) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
